// ===== hdl/ffea_pkg.sv =====
package ffea_pkg;

  localparam int BASE_W    = 36;
  localparam int LEN_W     = 24;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 36;
  localparam int CFG_IDX_W = 1;

  // Heap defaults: byte address 0x200000 in 4 KiB pages, 126 blocks of 256 pages.
  localparam int PAGE_SHIFT = 12;
  localparam logic [BASE_W-1:0] HEAP_START_DEFAULT = BASE_W'(36'h200000 >> PAGE_SHIFT);
  localparam logic [LEN_W-1:0]  HEAP_TOTAL_DEFAULT = LEN_W'(256 * 126);
  localparam logic [LEN_W:0]    LEN_LIMIT          = {1'b0, {LEN_W{1'b1}}};

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_TOTAL = 1'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FULL     = 2'd2,
    ST_ZERO     = 2'd3
  } status_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } ext_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_ZERO, RD_INC, RD_DEC, RD_LAST
  } rd_sel_t;

  typedef enum logic [3:0] {
    WR_NONE, WR_HEAP, WR_SHRINK, WR_DOWN, WR_UP,
    WR_MERGE_L, WR_MERGE_LR, WR_JOIN_R, WR_NEW
  } wr_sel_t;

  typedef enum logic [1:0] {
    USED_HOLD, USED_LOAD, USED_INC, USED_DEC
  } used_op_t;

  typedef struct packed {
    logic     latch;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    used_op_t used_op;
    logic     scan_cap;
    logic     page_cap;
    logic     finish;
    status_t  status;
  } ctl_t;

  typedef struct packed {
    logic count_zero;
    logic is_free;
    logic used_zero;
    logic used_full;
    logic fit;
    logic fit_exact;
    logic more;
    logic is_left;
    logic left_ok;
    logic lr_ok;
    logic right_ok;
    logic ins_at_end;
    logic at_ins_idx;
  } stat_t;

endpackage

// ===== hdl/ffea_ctrl.sv =====
module ffea_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           cfg_we,
  input  ffea_pkg::stat_t st,
  output ffea_pkg::ctl_t  ctl,
  output logic           busy
);
  import ffea_pkg::*;

  typedef enum logic [3:0] {
    S_RELOAD, S_IDLE, S_DISPATCH, S_A_SCAN, S_REMOVE,
    S_F_SCAN, S_F_DEC, S_INS_SHIFT, S_INS_WR
  } state_t;

  state_t state, state_next;

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    ctl         = '0;
    ctl.rd_sel  = RD_NONE;
    ctl.wr_sel  = WR_NONE;
    ctl.used_op = USED_HOLD;
    ctl.status  = ST_OK;
    case (state)
      S_RELOAD: begin
        ctl.wr_sel  = WR_HEAP;
        ctl.used_op = USED_LOAD;
        state_next  = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_we) begin
          state_next = S_RELOAD;
        end else if (start) begin
          ctl.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.count_zero) begin
          ctl.finish = 1'b1;
          ctl.status = ST_ZERO;
          state_next = S_IDLE;
        end else if (!st.is_free) begin
          if (st.used_zero) begin
            ctl.finish = 1'b1;
            ctl.status = ST_NO_SPACE;
            state_next = S_IDLE;
          end else begin
            ctl.rd_sel = RD_ZERO;
            state_next = S_A_SCAN;
          end
        end else if (st.used_zero) begin
          state_next = S_INS_WR;
        end else begin
          ctl.rd_sel = RD_ZERO;
          state_next = S_F_SCAN;
        end
      end
      // First fit: one entry examined per cycle.
      S_A_SCAN: begin
        if (st.fit) begin
          ctl.page_cap = 1'b1;
          if (st.fit_exact) begin
            if (st.more) begin
              ctl.rd_sel = RD_INC;
              state_next = S_REMOVE;
            end else begin
              ctl.used_op = USED_DEC;
              ctl.finish  = 1'b1;
              state_next  = S_IDLE;
            end
          end else begin
            ctl.wr_sel = WR_SHRINK;
            ctl.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else if (st.more) begin
          ctl.rd_sel = RD_INC;
        end else begin
          ctl.finish = 1'b1;
          ctl.status = ST_NO_SPACE;
          state_next = S_IDLE;
        end
      end
      // Close the gap: each entry moves one place down.
      S_REMOVE: begin
        ctl.wr_sel = WR_DOWN;
        if (st.more) begin
          ctl.rd_sel = RD_INC;
        end else begin
          ctl.used_op = USED_DEC;
          ctl.finish  = 1'b1;
          state_next  = S_IDLE;
        end
      end
      // Find the left and right neighbours of the freed range.
      S_F_SCAN: begin
        ctl.scan_cap = 1'b1;
        if (st.is_left && st.more) begin
          ctl.rd_sel = RD_INC;
        end else begin
          state_next = S_F_DEC;
        end
      end
      S_F_DEC: begin
        if (st.left_ok) begin
          if (st.lr_ok) begin
            ctl.wr_sel = WR_MERGE_LR;
            if (st.more) begin
              ctl.rd_sel = RD_INC;
              state_next = S_REMOVE;
            end else begin
              ctl.used_op = USED_DEC;
              ctl.finish  = 1'b1;
              state_next  = S_IDLE;
            end
          end else begin
            ctl.wr_sel = WR_MERGE_L;
            ctl.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else if (st.right_ok) begin
          ctl.wr_sel = WR_JOIN_R;
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end else if (st.used_full) begin
          ctl.finish = 1'b1;
          ctl.status = ST_FULL;
          state_next = S_IDLE;
        end else if (st.ins_at_end) begin
          ctl.wr_sel  = WR_NEW;
          ctl.used_op = USED_INC;
          ctl.finish  = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ctl.rd_sel = RD_LAST;
          state_next = S_INS_SHIFT;
        end
      end
      // Open a gap: each entry moves one place up, from the end.
      S_INS_SHIFT: begin
        ctl.wr_sel = WR_UP;
        if (st.at_ins_idx) begin
          state_next = S_INS_WR;
        end else begin
          ctl.rd_sel = RD_DEC;
        end
      end
      S_INS_WR: begin
        ctl.wr_sel  = WR_NEW;
        ctl.used_op = USED_INC;
        ctl.finish  = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RELOAD;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== hdl/ffea_datapath.sv =====
module ffea_datapath #(
  parameter int MAX_EXTENTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ffea_pkg::ctl_t                   ctl,
  output ffea_pkg::stat_t                  st,
  input  logic                             cmd,
  input  logic [ffea_pkg::BASE_W-1:0]      start_page,
  input  logic [ffea_pkg::CNT_W-1:0]       page_count,
  input  logic                             cfg_we,
  input  logic [ffea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffea_pkg::CFG_W-1:0]       cfg_data,
  output logic                             done,
  output logic [1:0]                       status,
  output logic [ffea_pkg::BASE_W-1:0]      alloc_page
);
  import ffea_pkg::*;

  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);

  ext_t              mem [MAX_EXTENTS];
  ext_t              rd_data;
  logic [IW-1:0]     rd_addr, cur;
  logic [IW-1:0]     wr_addr;
  ext_t              wr_data;
  logic [CW-1:0]     used;
  logic [BASE_W-1:0] heap_origin;
  logic [LEN_W-1:0]  heap_total;
  logic              cmd_q;
  logic [BASE_W-1:0] start_q;
  logic [CNT_W-1:0]  count_q;
  ext_t              left_e, right_e;
  logic [IW-1:0]     l_idx, r_idx;
  logic              has_left, has_right;
  logic [BASE_W-1:0] page_hold;

  logic [CW-1:0]     cur_inc;
  logic [CW-1:0]     ins_idx;
  logic [LEN_W-1:0]  new_left_len;
  logic [BASE_W:0]   left_end, left_end_new, right_meet;

  // Neighbour arithmetic, in one bit more than a page number.
  always_comb begin
    cur_inc      = CW'(cur) + CW'(1);
    ins_idx      = has_left ? (CW'(l_idx) + CW'(1)) : '0;
    new_left_len = left_e.len + LEN_W'(count_q);
    left_end     = {1'b0, left_e.base} + (BASE_W+1)'(left_e.len);
    left_end_new = {1'b0, left_e.base} + (BASE_W+1)'(new_left_len);
    right_meet   = {1'b0, start_q} + (BASE_W+1)'(count_q);
  end

  // Status towards the controller.
  always_comb begin
    st.count_zero = (count_q == '0);
    st.is_free    = (cmd_q == CMD_FREE);
    st.used_zero  = (used == '0);
    st.used_full  = (used == CW'(MAX_EXTENTS));
    st.fit        = (rd_data.len >= LEN_W'(count_q));
    st.fit_exact  = (rd_data.len == LEN_W'(count_q));
    st.more       = (cur_inc < used);
    st.is_left    = (cur == '0) ? (rd_data.base <= start_q) : (rd_data.base < start_q);
    st.left_ok    = has_left && ({1'b0, start_q} == left_end) &&
                    (((LEN_W+1)'(left_e.len) + (LEN_W+1)'(count_q)) <= LEN_LIMIT);
    st.lr_ok      = has_right && (left_end_new == {1'b0, right_e.base}) &&
                    (((LEN_W+1)'(new_left_len) + (LEN_W+1)'(right_e.len)) <= LEN_LIMIT);
    st.right_ok   = has_right && (right_meet == {1'b0, right_e.base}) &&
                    (((LEN_W+1)'(right_e.len) + (LEN_W+1)'(count_q)) <= LEN_LIMIT);
    st.ins_at_end = (ins_idx == used);
    st.at_ins_idx = (CW'(cur) == ins_idx);
  end

  // Read address follows the scan or shift direction.
  always_comb begin
    case (ctl.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_INC:  rd_addr = cur_inc[IW-1:0];
      RD_DEC:  rd_addr = cur - IW'(1);
      RD_LAST: rd_addr = IW'(used - CW'(1));
      default: rd_addr = cur;
    endcase
  end

  // Write address and data for each kind of table update.
  always_comb begin
    wr_addr = cur;
    wr_data = rd_data;
    case (ctl.wr_sel)
      WR_HEAP: begin
        wr_addr = '0;
        wr_data = '{base: heap_origin, len: heap_total};
      end
      WR_SHRINK: begin
        wr_data = '{base: rd_data.base + BASE_W'(count_q),
                    len:  rd_data.len - LEN_W'(count_q)};
      end
      WR_DOWN: wr_addr = cur - IW'(1);
      WR_UP:   wr_addr = cur_inc[IW-1:0];
      WR_MERGE_L: begin
        wr_addr = l_idx;
        wr_data = '{base: left_e.base, len: new_left_len};
      end
      WR_MERGE_LR: begin
        wr_addr = l_idx;
        wr_data = '{base: left_e.base, len: new_left_len + right_e.len};
      end
      WR_JOIN_R: begin
        wr_addr = r_idx;
        wr_data = '{base: start_q, len: right_e.len + LEN_W'(count_q)};
      end
      WR_NEW: begin
        wr_addr = ins_idx[IW-1:0];
        wr_data = '{base: start_q, len: LEN_W'(count_q)};
      end
      default: begin
        wr_addr = cur;
      end
    endcase
  end

  // Extent table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr_sel != WR_NONE) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    cur     <= rd_addr;
  end

  // Configuration registers and extent count.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_origin <= HEAP_START_DEFAULT;
      heap_total  <= HEAP_TOTAL_DEFAULT;
      used        <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_START) begin
          heap_origin <= cfg_data;
        end else if (cfg_index == REG_HEAP_TOTAL) begin
          heap_total <= cfg_data[LEN_W-1:0];
        end
      end
      case (ctl.used_op)
        USED_LOAD: used <= (heap_total != '0) ? CW'(1) : '0;
        USED_INC:  used <= used + CW'(1);
        USED_DEC:  used <= used - CW'(1);
        default:   used <= used;
      endcase
    end
  end

  // Request capture and neighbour registers.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q     <= cmd;
      start_q   <= start_page;
      count_q   <= page_count;
      has_left  <= 1'b0;
      has_right <= 1'b0;
    end
    if (ctl.scan_cap) begin
      if (st.is_left) begin
        left_e   <= rd_data;
        l_idx    <= cur;
        has_left <= 1'b1;
      end else begin
        right_e   <= rd_data;
        r_idx     <= cur;
        has_right <= 1'b1;
      end
    end
    if (ctl.page_cap) begin
      page_hold <= rd_data.base;
    end
  end

  // Result strobe for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      status <= ctl.status;
      if (ctl.status == ST_OK && cmd_q == CMD_ALLOC) begin
        alloc_page <= ctl.page_cap ? rd_data.base : page_hold;
      end else begin
        alloc_page <= '0;
      end
    end
  end

endmodule

// ===== hdl/first_fit_extent_allocator_unit.sv =====
// A request is dispatched, then the table is scanned entry by entry and the entries after the
// changed one are moved; a free adds a neighbour check. The done strobe is registered.
// Throughput: one request at a time; the next is accepted at the edge that ends the strobe.
// Reset and each configuration write taken while idle reload the table, with busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
module first_fit_extent_allocator_unit #(
  parameter int MAX_EXTENTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd,
  input  logic [ffea_pkg::BASE_W-1:0]    start_page,
  input  logic [ffea_pkg::CNT_W-1:0]     page_count,
  input  logic                           cfg_we,
  input  logic [ffea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffea_pkg::CFG_W-1:0]     cfg_data,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [ffea_pkg::BASE_W-1:0]    alloc_page
);
  import ffea_pkg::*;

  ctl_t  ctl;
  stat_t st;

  ffea_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_we (cfg_we),
    .st     (st),
    .ctl    (ctl),
    .busy   (busy)
  );

  ffea_datapath #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .st         (st),
    .cmd        (cmd),
    .start_page (start_page),
    .page_count (page_count),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .alloc_page (alloc_page)
  );

endmodule
